FILE: hdl/integer_field_formatter_defines.svh
// Assertion macros shared by the integer field formatter RTL.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef INTEGER_FIELD_FORMATTER_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every clock while out of reset.
`define IFMT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");
// Trigger in one cycle implies expression in the next.
`define IFMT_ASSERT_NEXT(lbl, trig, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error("%m: check failed");
`else
`define IFMT_ASSERT(lbl, prop)
`define IFMT_ASSERT_NEXT(lbl, trig, expr)
`endif
`endif

FILE: hdl/ifmt_pkg.sv
// Shared types, codes and constants of the integer field formatter.
// No dependencies; imported by the controller, datapath and top level.
package ifmt_pkg;

	localparam int MAX_FIELD  = 63;               // longest field emitted
	localparam int VAL_W      = 32;
	localparam int MODE_W     = 3;
	localparam int SIZE_W     = 2;
	localparam int FW_W       = 6;                // width / precision fields
	localparam int LEN_W      = FW_W + 1;         // sign/prefix + precision fits
	localparam int CNT_W      = $clog2(MAX_FIELD + 1);
	localparam int MAX_DIGITS = 12;
	localparam int DIG_W      = $clog2(MAX_DIGITS + 1);
	localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
	localparam int PROD_W     = 2 * VAL_W;

	// x / 10 == (x * RECIP_DEC) >> REC_SHIFT for every 32-bit x
	localparam logic [VAL_W-1:0] RECIP_DEC = 32'hCCCC_CCCD;
	localparam int REC_SHIFT = 35;

	// conversion modes
	localparam logic [MODE_W-1:0] MODE_SDEC = 3'd0;
	localparam logic [MODE_W-1:0] MODE_UDEC = 3'd1;
	localparam logic [MODE_W-1:0] MODE_OCT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HEXL = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HEXU = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CHAR = 3'd5;

	// argument sizes
	localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd0;
	localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
	localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd2;

	// ASCII
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_X_LO  = CH_X_UP | CASE_BIT;
	localparam logic [7:0] HEX_GAP  = 8'h41 - (8'h39 + 8'h01); // '9'+1 up to 'A'

	typedef struct packed {
		logic load;   // capture request
		logic prep;   // size cut and sign handling
		logic mul;    // reciprocal multiply
		logic dig;    // produce one digit
		logic lay1;   // prefix and zero counts
		logic lay2;   // segment boundaries
		logic emit;   // drive characters
	} ifmt_cmd_t;

	typedef struct packed {
		logic is_char;
		logic div_done;
		logic emit_last;
	} ifmt_stat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		c = CH_ZERO + 8'(d);
		if (d > 4'd9)
			c = c + HEX_GAP + (upper ? 8'h00 : CASE_BIT);
		return c;
	endfunction

endpackage

FILE: hdl/integer_field_formatter.sv
// Top level of the integer field formatter.
// Depends on ifmt_pkg, ifmt_ctrl and ifmt_dp.
//
// Formats one integer conversion request (decimal signed or unsigned, octal,
// hex in either case, or a raw character) into a field of ASCII characters,
// one character per output transfer, with last set on the final one. The
// value is cut to 8/16/32 bits first; signed decimal prints '-', ' ' or '+'
// ahead of the magnitude, alternate form adds 0x/0X for nonzero hex and a
// single leading 0 for octal, precision zeros and zero padding sit after
// the sign or prefix, and width padding is on the left unless left
// justified. Fields longer than MAX_FIELD (63) are cut at that length.
// Requests are handled one at a time: in_stall stays high from the request
// transfer until the last character has been loaded into the output
// register. A request transfers in the idle state and then passes the size
// cut and sign, a digit loop with a 32x32 reciprocal multiply and a digit
// forming step per digit (1..11 digits, none for character mode), two
// layout steps, and emission of one character per step into the output
// register (1..63 characters) while the output does not stall. The next
// request is taken while the last character still waits in the output
// register.
module integer_field_formatter (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ifmt_pkg::VAL_W-1:0]    value,
	input  logic [ifmt_pkg::MODE_W-1:0]   mode,
	input  logic [ifmt_pkg::SIZE_W-1:0]   size,
	input  logic                          alt_form,
	input  logic                          left_justify,
	input  logic                          zero_pad,
	input  logic                          plus_sign,
	input  logic                          space_sign,
	input  logic [ifmt_pkg::FW_W-1:0]     field_width,
	input  logic [ifmt_pkg::FW_W-1:0]     min_digits,
	// character channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_char,
	output logic                          last
);
	import ifmt_pkg::*;

	ifmt_cmd_t  cmd;
	ifmt_stat_t stat;

	ifmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ifmt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.value        (value),
		.mode         (mode),
		.size         (size),
		.alt_form     (alt_form),
		.left_justify (left_justify),
		.zero_pad     (zero_pad),
		.plus_sign    (plus_sign),
		.space_sign   (space_sign),
		.field_width  (field_width),
		.min_digits   (min_digits),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.last         (last)
	);

endmodule

FILE: hdl/ifmt_ctrl.sv
// Sequencer of the integer field formatter: accept, digit loop, layout, emit.
// Depends on ifmt_pkg and integer_field_formatter_defines.svh.
`include "integer_field_formatter_defines.svh"
module ifmt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ifmt_pkg::ifmt_stat_t stat,
	output ifmt_pkg::ifmt_cmd_t  cmd
);
	import ifmt_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PREP = 7'b0000010,
		S_MUL  = 7'b0000100,
		S_DIG  = 7'b0001000,
		S_LAY1 = 7'b0010000,
		S_LAY2 = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid)
					state_d = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = stat.is_char ? S_LAY1 : S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIG;
			end
			S_DIG: begin
				cmd.dig = 1'b1;
				state_d = stat.div_done ? S_LAY1 : S_MUL;
			end
			S_LAY1: begin
				cmd.lay1 = 1'b1;
				state_d  = S_LAY2;
			end
			S_LAY2: begin
				cmd.lay2 = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.emit_last)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	`IFMT_ASSERT_NEXT(a_accept_starts, in_valid && state_q == S_IDLE, state_q == S_PREP)
	`IFMT_ASSERT_NEXT(a_last_ends, stat.emit_last && state_q == S_EMIT, state_q == S_IDLE)

endmodule

FILE: hdl/ifmt_dp.sv
// Datapath of the integer field formatter: request registers, digit unit,
// digit buffer, layout and output register. Depends on ifmt_pkg and the defines.
`include "integer_field_formatter_defines.svh"
module ifmt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ifmt_pkg::ifmt_cmd_t           cmd,
	output ifmt_pkg::ifmt_stat_t          stat,
	input  logic [ifmt_pkg::VAL_W-1:0]    value,
	input  logic [ifmt_pkg::MODE_W-1:0]   mode,
	input  logic [ifmt_pkg::SIZE_W-1:0]   size,
	input  logic                          alt_form,
	input  logic                          left_justify,
	input  logic                          zero_pad,
	input  logic                          plus_sign,
	input  logic                          space_sign,
	input  logic [ifmt_pkg::FW_W-1:0]     field_width,
	input  logic [ifmt_pkg::FW_W-1:0]     min_digits,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_char,
	output logic                          last
);
	import ifmt_pkg::*;

	// request
	logic [VAL_W-1:0]  raw_q;
	logic [MODE_W-1:0] mode_q;
	logic [SIZE_W-1:0] size_q;
	logic              alt_q, left_q, zpad_q, plus_q, space_q;
	logic [FW_W-1:0]   width_q, prec_q;

	// digit loop
	logic [VAL_W-1:0]  m_q;
	logic              neg_q, zero_q;
	logic [PROD_W-1:0] prod_q;
	logic [7:0]        buf_q [MAX_DIGITS];
	logic [DIG_W-1:0]  ndig_q;

	// layout
	logic [FW_W-1:0]   nzero_q;
	logic [1:0]        npre_q;
	logic [7:0]        pre0_q, pre1_q;
	logic [LEN_W-1:0]  body_q, b0_q, b1_q, b3_q, b4_q;
	logic [CNT_W-1:0]  emit_q, pos_q;

	// output register
	logic              out_valid_q, last_q;
	logic [7:0]        out_char_q;

	// size cut and sign
	logic [VAL_W-1:0] mask_c, masked_c, mag_c;
	logic             sbit_c, neg_c;

	always_comb begin
		case (size_q)
			SIZE_HALF: begin
				mask_c = 32'h0000_FFFF;
				sbit_c = raw_q[15];
			end
			SIZE_BYTE: begin
				mask_c = 32'h0000_00FF;
				sbit_c = raw_q[7];
			end
			default: begin
				mask_c = '1;
				sbit_c = raw_q[VAL_W-1];
			end
		endcase
		masked_c = raw_q & mask_c;
		neg_c    = (mode_q == MODE_SDEC) && sbit_c;
		mag_c    = neg_c ? (((~masked_c) + VAL_W'(1)) & mask_c) : masked_c;
	end

	// one digit per step; decimal via the registered reciprocal product
	logic [VAL_W-1:0] q_c, qdec_c;
	logic [3:0]       r_c, tenq_c;
	logic             div_done_c;

	always_comb begin
		qdec_c = VAL_W'(prod_q >> REC_SHIFT);
		tenq_c = {qdec_c[0], 3'b000} + {qdec_c[2:0], 1'b0};
		case (mode_q) inside
			MODE_OCT: begin
				q_c = {3'b000, m_q[VAL_W-1:3]};
				r_c = {1'b0, m_q[2:0]};
			end
			MODE_HEXL, MODE_HEXU: begin
				q_c = {4'b0000, m_q[VAL_W-1:4]};
				r_c = m_q[3:0];
			end
			default: begin
				q_c = qdec_c;
				r_c = m_q[3:0] - tenq_c;
			end
		endcase
		div_done_c = (q_c == '0) || (ndig_q == DIG_W'(MAX_DIGITS - 1));
	end

	// prefix and precision zeros
	logic [FW_W-1:0]  nzero_c;
	logic [1:0]       npre_c;
	logic [7:0]       pre0_c, pre1_c;
	logic             is_char_c;

	always_comb begin
		is_char_c = (mode_q == MODE_CHAR);
		nzero_c   = '0;
		if (!is_char_c && (prec_q > FW_W'(ndig_q)))
			nzero_c = prec_q - FW_W'(ndig_q);
		npre_c = 2'd0;
		pre0_c = CH_ZERO;
		pre1_c = CH_X_LO;
		case (mode_q) inside
			MODE_SDEC: begin
				if (neg_q) begin
					npre_c = 2'd1;
					pre0_c = CH_MINUS;
				end else if (space_q) begin
					npre_c = 2'd1;
					pre0_c = CH_SPACE;
				end else if (plus_q && !zero_q) begin
					npre_c = 2'd1;
					pre0_c = CH_PLUS;
				end
			end
			MODE_HEXL, MODE_HEXU: begin
				if (alt_q && !zero_q)
					npre_c = 2'd2;
				if (mode_q == MODE_HEXU)
					pre1_c = CH_X_UP;
			end
			MODE_OCT: begin
				// octal zero only where the digits do not already lead with one
				if (alt_q && (nzero_c == '0) && !zero_q)
					npre_c = 2'd1;
			end
			default: ;
		endcase
	end

	// segment boundaries
	logic [LEN_W-1:0] pad_c, lsp_c, zp_c, rsp_c;
	logic [LEN_W-1:0] b0_c, b1_c, b3_c, b4_c, n_c;
	logic             zp_mode_c;
	logic [CNT_W-1:0] emit_c;

	always_comb begin
		pad_c = '0;
		if (LEN_W'(width_q) > body_q)
			pad_c = LEN_W'(width_q) - body_q;
		zp_mode_c = zpad_q && (prec_q == '0);
		lsp_c = (!left_q && !zp_mode_c) ? pad_c : '0;
		zp_c  = (!left_q && zp_mode_c) ? pad_c : '0;
		rsp_c = left_q ? pad_c : '0;
		b0_c  = lsp_c;
		b1_c  = b0_c + LEN_W'(npre_q);
		b3_c  = b1_c + zp_c + LEN_W'(nzero_q);
		b4_c  = b3_c + LEN_W'(ndig_q);
		n_c   = b4_c + rsp_c;
		emit_c = (n_c > LEN_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : n_c[CNT_W-1:0];
	end

	// character at the current position
	logic [LEN_W-1:0] p_c, rel_c, didx_c;
	logic [7:0]       ch_c;
	logic             last_c, out_free_c, fire_c;

	always_comb begin
		p_c    = LEN_W'(pos_q);
		rel_c  = p_c - b0_q;
		didx_c = b4_q - LEN_W'(1) - p_c;
		if (p_c < b0_q)
			ch_c = CH_SPACE;
		else if (p_c < b1_q)
			ch_c = rel_c[0] ? pre1_q : pre0_q;
		else if (p_c < b3_q)
			ch_c = CH_ZERO;
		else if (p_c < b4_q)
			ch_c = buf_q[didx_c[DIG_IDX_W-1:0]];
		else
			ch_c = CH_SPACE;
		last_c     = ((pos_q + CNT_W'(1)) == emit_q);
		out_free_c = !out_valid_q || !out_stall;
		fire_c     = cmd.emit && out_free_c;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q   <= value;
			mode_q  <= mode;
			size_q  <= size;
			alt_q   <= alt_form;
			left_q  <= left_justify;
			zpad_q  <= zero_pad;
			plus_q  <= plus_sign;
			space_q <= space_sign;
			width_q <= field_width;
			prec_q  <= min_digits;
		end
		if (cmd.prep) begin
			m_q    <= mag_c;
			neg_q  <= neg_c;
			zero_q <= (mag_c == '0);
			if (is_char_c) begin
				buf_q[0] <= raw_q[7:0];
				ndig_q   <= DIG_W'(1);
			end else begin
				ndig_q <= '0;
			end
		end
		if (cmd.mul)
			prod_q <= m_q * RECIP_DEC;
		if (cmd.dig) begin
			buf_q[ndig_q[DIG_IDX_W-1:0]] <= hex_char(r_c, mode_q == MODE_HEXU);
			ndig_q <= ndig_q + DIG_W'(1);
			m_q    <= q_c;
		end
		if (cmd.lay1) begin
			nzero_q <= nzero_c;
			npre_q  <= npre_c;
			pre0_q  <= pre0_c;
			pre1_q  <= pre1_c;
			body_q  <= LEN_W'(npre_c) + LEN_W'(nzero_c) + LEN_W'(ndig_q);
		end
		if (cmd.lay2) begin
			b0_q   <= b0_c;
			b1_q   <= b1_c;
			b3_q   <= b3_c;
			b4_q   <= b4_c;
			emit_q <= emit_c;
			pos_q  <= '0;
		end
		if (fire_c) begin
			out_char_q <= ch_c;
			last_q     <= last_c;
			pos_q      <= pos_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire_c)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid      = out_valid_q;
	assign out_char       = out_char_q;
	assign last           = last_q;
	assign stat.is_char   = is_char_c;
	assign stat.div_done  = div_done_c;
	assign stat.emit_last = fire_c && last_c;

	`IFMT_ASSERT(a_ndig_range, cmd.lay1 |-> (ndig_q != '0 && ndig_q <= DIG_W'(MAX_DIGITS)))
	`IFMT_ASSERT(a_emit_range, cmd.emit |-> (emit_q != '0 && emit_q <= CNT_W'(MAX_FIELD)))
	`IFMT_ASSERT(a_pos_bound, cmd.emit |-> (pos_q < emit_q))

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Testbench for integer_field_formatter: directed and random conversion requests,
// a self-contained field predictor and a per-character scoreboard.
// Depends on ifmt_pkg and the formatter RTL only.
module testbench;
	import ifmt_pkg::*;

	localparam int LIMIT     = 600_000;  // cycle budget for the whole run
	localparam int SETTLE    = 100;      // quiet cycles after the last character
	localparam int HOLD_AT   = 30;       // request count that starts the long hold
	localparam int LONG_HOLD = 300;      // receiver hold-off length in cycles
	localparam int RAND_REQS = 100;

	localparam logic [7:0] LETTER_LO = 8'h61;  // 'a'
	localparam logic [7:0] LETTER_UP = 8'h41;  // 'A'

	// spare codes, handled as unsigned decimal and full word
	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
	localparam logic [SIZE_W-1:0] SIZE_SPARE   = 2'd3;

	// flag masks for directed requests: {alt, left, zero, plus, space}
	localparam logic [4:0] F_NONE  = 5'b00000;
	localparam logic [4:0] F_ALT   = 5'b10000;
	localparam logic [4:0] F_LEFT  = 5'b01000;
	localparam logic [4:0] F_ZERO  = 5'b00100;
	localparam logic [4:0] F_PLUS  = 5'b00010;
	localparam logic [4:0] F_SPACE = 5'b00001;

	// one conversion request plus the sender's idle cycles after it
	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [MODE_W-1:0] mode;
		logic [SIZE_W-1:0] size;
		logic              alt_form;
		logic              left_justify;
		logic              zero_pad;
		logic              plus_sign;
		logic              space_sign;
		logic [FW_W-1:0]   field_width;
		logic [FW_W-1:0]   min_digits;
		logic [3:0]        gap;          // idle cycles after this transfer
		logic              drain_first;  // hold off until all characters are back
	} fmt_req_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
	} field_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_char;
	logic last;

	fmt_req_t    cur_req = '0;      // request on the input ports
	fmt_req_t    pending[$];        // requests not yet offered
	field_char_t field_chars[$];    // characters still owed by the block

	logic req_taken = 1'b0;         // input transfer at the last rising edge
	logic char_taken = 1'b0;        // output transfer at the last rising edge
	int   req_count = 0;
	int   mismatches = 0;
	int   cycles = 0;
	int   stall_left = 0;
	bit   long_hold_done = 1'b0;

	logic [VAL_W-1:0]  value;
	logic [MODE_W-1:0] mode;
	logic [SIZE_W-1:0] size;
	logic              alt_form, left_justify, zero_pad, plus_sign, space_sign;
	logic [FW_W-1:0]   field_width, min_digits;

	// payload ports follow the held request, so a stalled payload never moves
	assign value        = cur_req.value;
	assign mode         = cur_req.mode;
	assign size         = cur_req.size;
	assign alt_form     = cur_req.alt_form;
	assign left_justify = cur_req.left_justify;
	assign zero_pad     = cur_req.zero_pad;
	assign plus_sign    = cur_req.plus_sign;
	assign space_sign   = cur_req.space_sign;
	assign field_width  = cur_req.field_width;
	assign min_digits   = cur_req.min_digits;

	integer_field_formatter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.mode         (mode),
		.size         (size),
		.alt_form     (alt_form),
		.left_justify (left_justify),
		.zero_pad     (zero_pad),
		.plus_sign    (plus_sign),
		.space_sign   (space_sign),
		.field_width  (field_width),
		.min_digits   (min_digits),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.last         (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Builds the full field for one request and queues its characters.
	// Layout: [spaces] sign/prefix [zero pad] [precision zeros] digits [spaces],
	// cut to MAX_FIELD with the mark on the last character kept.
	function automatic void format_field(input fmt_req_t r);
		logic [VAL_W-1:0] mag, mask, signbit, radix, rest, rem;
		logic [7:0] digs[$];
		logic [7:0] head[$];
		logic [7:0] line[$];
		logic neg, upper, hex, zero_fill;
		int nzero, body, pad, emit;
		neg = 1'b0;
		nzero = 0;
		upper = (r.mode == MODE_HEXU);
		hex = (r.mode == MODE_HEXL) || upper;
		if (r.mode == MODE_CHAR) begin
			// raw low byte, even a NUL; precision and sign flags do not apply
			digs.push_back(r.value[7:0]);
		end else begin
			mask = '1;
			signbit = 32'h8000_0000;
			if (r.size == SIZE_HALF) begin
				mask = 32'h0000_FFFF;
				signbit = 32'h0000_8000;
			end else if (r.size == SIZE_BYTE) begin
				mask = 32'h0000_00FF;
				signbit = 32'h0000_0080;
			end
			mag = r.value & mask;
			if (r.mode == MODE_SDEC && (mag & signbit) != 0) begin
				neg = 1'b1;
				mag = (~mag + 1) & mask;
			end
			// spare mode codes fall through to unsigned decimal
			radix = (r.mode == MODE_OCT) ? 32'd8 : (hex ? 32'd16 : 32'd10);
			rest = mag;
			do begin
				rem = rest % radix;
				digs.push_front((rem < 10) ? CH_ZERO + 8'(rem) :
					(upper ? LETTER_UP : LETTER_LO) + 8'(rem - 10));
				rest = rest / radix;
			end while (rest != 0);
			if (r.min_digits > digs.size())
				nzero = r.min_digits - digs.size();
			if (r.mode == MODE_SDEC) begin
				if (neg)
					head.push_back(CH_MINUS);
				else if (r.space_sign)
					head.push_back(CH_SPACE);
				else if (r.plus_sign && mag != 0)
					head.push_back(CH_PLUS);
			end else if (r.alt_form && hex && mag != 0) begin
				head.push_back(CH_ZERO);
				head.push_back(upper ? CH_X_UP : CH_X_LO);
			end else if (r.alt_form && r.mode == MODE_OCT && nzero == 0 &&
					digs[0] != CH_ZERO) begin
				// octal alternate form: one leading zero unless already there
				head.push_back(CH_ZERO);
			end
		end
		body = head.size() + nzero + digs.size();
		pad = (int'(r.field_width) > body) ? int'(r.field_width) - body : 0;
		// zero padding only when right-aligned and no precision given
		zero_fill = !r.left_justify && r.zero_pad && r.min_digits == 0;
		if (!r.left_justify && !zero_fill)
			repeat (pad) line.push_back(CH_SPACE);
		line = {line, head};
		if (zero_fill)
			repeat (pad) line.push_back(CH_ZERO);
		repeat (nzero) line.push_back(CH_ZERO);
		line = {line, digs};
		if (r.left_justify)
			repeat (pad) line.push_back(CH_SPACE);
		emit = (line.size() > MAX_FIELD) ? MAX_FIELD : line.size();
		for (int i = 0; i < emit; i++)
			field_chars.push_back('{ch: line[i], is_last: (i == emit - 1)});
	endfunction

	task automatic add_req(input logic [VAL_W-1:0] v, input logic [MODE_W-1:0] m,
			input logic [SIZE_W-1:0] s, input logic [4:0] flags,
			input logic [FW_W-1:0] w, input logic [FW_W-1:0] p);
		fmt_req_t r;
		r = '0;
		r.value = v;
		r.mode = m;
		r.size = s;
		{r.alt_form, r.left_justify, r.zero_pad, r.plus_sign, r.space_sign} = flags;
		r.field_width = w;
		r.min_digits = p;
		r.gap = 4'($urandom_range(0, 9));
		pending.push_back(r);
	endtask

	// Sender: offers the next pending request at the falling edge once the
	// current one has transferred and its idle gap has run out.
	always @(negedge clk) begin
		logic [3:0] gap_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = '0;
		end else if (!in_valid || req_taken) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left = gap_left - 4'd1;
			end else if (pending.size() != 0 &&
					!(pending[0].drain_first && field_chars.size() != 0)) begin
				cur_req <= pending[0];
				gap_left = pending[0].gap;
				void'(pending.pop_front());
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a fresh random stall length after every character, none during
	// a calm stretch, and one long hold-off that backs the block up.
	always @(negedge clk) begin
		bit rx_calm;
		rx_calm = (req_count >= 60 && req_count < 80);
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (req_count == HOLD_AT && !long_hold_done) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD;
			end else if (char_taken) begin
				stall_left = rx_calm ? 0 : $urandom_range(0, 9);
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left = stall_left - 1;
		end
	end

	// Scoreboard: predict on each request transfer, then check each character
	// transfer against the oldest owed character.
	always @(posedge clk) begin
		field_char_t want;
		if (arst_n) begin
			req_taken <= in_valid && !in_stall;
			char_taken <= out_valid && !out_stall;
			if (in_valid && !in_stall) begin
				format_field(cur_req);
				req_count <= req_count + 1;
			end
			if (out_valid && !out_stall) begin
				if (field_chars.size() == 0) begin
					$display("%0t: unexpected character: expected none, actual char %h last %b",
						$time, out_char, last);
					mismatches = mismatches + 1;
				end else begin
					want = field_chars.pop_front();
					if (out_char !== want.ch) begin
						$display("%0t: out_char mismatch: expected %h, actual %h",
							$time, want.ch, out_char);
						mismatches = mismatches + 1;
					end
					if (last !== want.is_last) begin
						$display("%0t: last mismatch: expected %b, actual %b",
							$time, want.is_last, last);
						mismatches = mismatches + 1;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		fmt_req_t r;

		// directed: field extremes, every mode and each corner of the layout
		add_req(32'h0000_0000, MODE_SDEC, SIZE_WORD, F_NONE, 6'd0, 6'd0);
		add_req(32'h8000_0000, MODE_SDEC, SIZE_WORD, F_NONE, 6'd0, 6'd0);
		add_req(32'hFFFF_FFFF, MODE_UDEC, SIZE_WORD, F_NONE, 6'd0, 6'd0);
		add_req(32'hFFFF_FFFF, MODE_OCT, SIZE_WORD, F_ALT, 6'd0, 6'd0);
		add_req(32'h0000_0000, MODE_OCT, SIZE_WORD, F_ALT, 6'd0, 6'd0);
		add_req(32'h0000_0008, MODE_OCT, SIZE_WORD, F_ALT, 6'd0, 6'd4);
		add_req(32'hDEAD_BEEF, MODE_HEXL, SIZE_WORD, F_ALT, 6'd0, 6'd0);
		add_req(32'h0000_0000, MODE_HEXU, SIZE_WORD, F_ALT, 6'd5, 6'd0);
		add_req(32'h1234_ABCD, MODE_HEXU, SIZE_HALF, F_ALT | F_ZERO, 6'd10, 6'd0);
		add_req(32'h0000_0080, MODE_SDEC, SIZE_BYTE, F_NONE, 6'd0, 6'd0);
		add_req(32'hFFFF_7FFF, MODE_SDEC, SIZE_HALF, F_PLUS, 6'd0, 6'd0);
		add_req(32'h0000_0000, MODE_SDEC, SIZE_WORD, F_PLUS, 6'd3, 6'd0);
		add_req(32'h0000_0005, MODE_SDEC, SIZE_WORD, F_SPACE | F_PLUS, 6'd0, 6'd0);
		add_req(32'hFFFF_FFFB, MODE_SDEC, SIZE_WORD, F_ZERO, 6'd8, 6'd0);
		add_req(32'd42, MODE_SDEC, SIZE_WORD, F_ZERO | F_PLUS, 6'd10, 6'd6);
		add_req(32'd42, MODE_SDEC, SIZE_WORD, F_LEFT | F_ZERO, 6'd10, 6'd0);
		add_req(32'h0000_0041, MODE_CHAR, SIZE_BYTE, F_LEFT | F_ALT, 6'd5, 6'd9);
		add_req(32'hFFFF_FF00, MODE_CHAR, SIZE_HALF, F_PLUS | F_SPACE, 6'd3, 6'd0);
		add_req(32'd1234, MODE_SPARE_A, SIZE_WORD, F_PLUS | F_ALT, 6'd0, 6'd0);
		add_req(32'hFFFF_FFFF, MODE_SPARE_B, SIZE_SPARE, F_SPACE, 6'd0, 6'd0);
		add_req(32'hFFFF_FFFF, MODE_SDEC, SIZE_WORD, F_NONE, 6'd63, 6'd63);
		add_req(32'd7, MODE_UDEC, SIZE_WORD, F_LEFT, 6'd63, 6'd0);
		add_req(32'hFFFF_FFFF, MODE_SPARE_B, SIZE_SPARE,
			F_ALT | F_LEFT | F_ZERO | F_PLUS | F_SPACE, 6'd63, 6'd63);

		// random: mostly small widths and no precision, a few of the largest
		for (int i = 0; i < RAND_REQS; i++) begin
			r = '0;
			case ($urandom_range(0, 3))
				0: r.value = $urandom_range(0, 20);
				1: r.value = 32'(0) - $urandom_range(1, 300);
				default: r.value = $urandom();
			endcase
			r.mode = ($urandom_range(0, 9) == 0) ?
				MODE_W'($urandom_range(MODE_SPARE_A, MODE_SPARE_B)) :
				MODE_W'($urandom_range(MODE_SDEC, MODE_CHAR));
			r.size = SIZE_W'($urandom_range(0, 3));
			r.alt_form = 1'($urandom_range(0, 1));
			r.left_justify = 1'($urandom_range(0, 1));
			r.zero_pad = 1'($urandom_range(0, 1));
			r.plus_sign = 1'($urandom_range(0, 1));
			r.space_sign = 1'($urandom_range(0, 1));
			r.field_width = ($urandom_range(0, 9) == 0) ? FW_W'($urandom_range(0, 63)) :
				FW_W'($urandom_range(0, 16));
			if ($urandom_range(0, 2) == 0)
				r.min_digits = ($urandom_range(0, 5) == 0) ? FW_W'($urandom_range(0, 63)) :
					FW_W'($urandom_range(1, 12));
			// back-to-back stretch, plus one pause until the block has drained
			r.gap = (i >= 40 && i < 60) ? 4'd0 : 4'($urandom_range(0, 9));
			r.drain_first = (i == 70);
			pending.push_back(r);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (field_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
